// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the timer table RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, skipped while reset is asserted.
`define STT_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("%m: check failed");

// Clocked check that also holds during reset.
`define STT_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) (prop)) \
    else $error("%m: check failed");

`endif

// ----- src/stt_pkg.sv -----
// ----------------------------------------------------------------------------
// stt_pkg
// Types and constants of the software timer table.
// ----------------------------------------------------------------------------
package stt_pkg;

  localparam int MaxTasks  = 16;
  localparam int SlotW     = $clog2(MaxTasks);
  localparam int IdW       = 4;
  localparam int TimeW     = 32;
  localparam int CmdW      = 2;

  typedef enum logic [CmdW-1:0] {
    CMD_SCHEDULE = 2'd0,
    CMD_CANCEL   = 2'd1,
    CMD_TICK     = 2'd2
  } cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_APPLY = 4'b0010,
    ST_SCAN  = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_e;

  typedef struct packed {
    logic [CmdW-1:0]  cmd;
    logic [IdW-1:0]   task_id;
    logic [TimeW-1:0] offset_ms;
    logic [TimeW-1:0] now_ms;
  } stt_in_t;

  typedef struct packed {
    logic             fired_valid;
    logic [IdW-1:0]   fired_id;
    logic             last;
    logic             next_valid;
    logic [IdW-1:0]   next_id;
    logic [TimeW-1:0] next_deadline;
  } stt_out_t;

  // Control from the sequencer to the scan unit.
  typedef struct packed {
    logic             clear;
    logic             step;
    logic             tick;
    logic [SlotW-1:0] slot;
  } scan_ctrl_t;

  // Earliest armed slot found so far.
  typedef struct packed {
    logic             valid;
    logic [SlotW-1:0] id;
    logic [TimeW-1:0] deadline;
  } next_t;

endpackage

// ----- src/stt_ram.sv -----
// ----------------------------------------------------------------------------
// stt_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module stt_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/stt_scan.sv -----
// ----------------------------------------------------------------------------
// stt_scan
// Shared compare unit: one slot per step, due check against now and running
// search for the earliest armed deadline.
// ----------------------------------------------------------------------------
module stt_scan (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  stt_pkg::scan_ctrl_t             ctrl_i,
  input  logic                            armed_i,
  input  logic [stt_pkg::TimeW-1:0]       deadline_i,
  input  logic [stt_pkg::TimeW-1:0]       now_i,
  output logic                            fire_o,
  output stt_pkg::next_t                  best_o
);

  logic                        best_vld_q, best_vld_d;
  logic [stt_pkg::SlotW-1:0]   best_id_q, best_id_d;
  logic [stt_pkg::TimeW-1:0]   best_dl_q, best_dl_d;
  logic                        keep;

  // A slot that fires is freed, so it no longer competes for earliest.
  assign fire_o = ctrl_i.step && ctrl_i.tick && armed_i && (deadline_i <= now_i);
  assign keep   = armed_i && !fire_o;

  always_comb begin
    best_vld_d = best_vld_q;
    best_id_d  = best_id_q;
    best_dl_d  = best_dl_q;
    if (ctrl_i.clear) begin
      best_vld_d = 1'b0;
    end else if (ctrl_i.step && keep && (!best_vld_q || deadline_i < best_dl_q)) begin
      best_vld_d = 1'b1;
      best_id_d  = ctrl_i.slot;
      best_dl_d  = deadline_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_vld_q <= 1'b0;
    end else begin
      best_vld_q <= best_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_id_q <= best_id_d;
    best_dl_q <= best_dl_d;
  end

  assign best_o.valid    = best_vld_q;
  assign best_o.id       = best_vld_q ? best_id_q : '0;
  assign best_o.deadline = best_vld_q ? best_dl_q : '0;

endmodule

// ----- src/software_timer_table.sv -----
// ----------------------------------------------------------------------------
// software_timer_table
// One-shot timer table with one slot per task id: schedule, cancel and tick
// commands, fired slots reported in slot order with the earliest armed slot.
// ----------------------------------------------------------------------------
//   channel  handshake                 payload
//   in       in_valid_i / in_ready_o   in_i  (cmd, task_id, offset_ms, now_ms)
//   out      out_valid_o / out_ready_i out_o (fired and next-task report)
//
// One item at a time; in_ready_o is high only in idle. Schedule, cancel and the
// unused command first pass the apply state for the slot update. Every item then
// scans all MaxTasks slots through the deadline RAM and the shared compare unit,
// and emits one result per fired slot (one if none fired). Out stalls hold the
// current result. Reset frees every slot; the deadline RAM needs no clearing.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module software_timer_table (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  stt_pkg::stt_in_t in_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output stt_pkg::stt_out_t out_o,
  output logic             out_valid_o,
  input  logic             out_ready_i
);

  localparam logic [stt_pkg::SlotW-1:0] LastSlot = stt_pkg::SlotW'(stt_pkg::MaxTasks - 1);

  stt_pkg::state_e               state_q, state_d;
  stt_pkg::stt_in_t              item_q, item_d;
  logic [stt_pkg::MaxTasks-1:0]  armed_q, armed_d;
  logic [stt_pkg::MaxTasks-1:0]  mask_q, mask_d;
  logic [stt_pkg::SlotW-1:0]     iss_q, iss_d;
  logic                          iss_done_q, iss_done_d;
  logic                          proc_vld_q, proc_vld_d;
  logic [stt_pkg::SlotW-1:0]     proc_idx_q, proc_idx_d;

  logic                          ram_we;
  logic [stt_pkg::SlotW-1:0]     ram_waddr;
  logic [stt_pkg::SlotW-1:0]     ram_raddr;
  logic [stt_pkg::TimeW-1:0]     ram_rdata;
  logic [stt_pkg::TimeW:0]       sum_ext;
  logic [stt_pkg::TimeW-1:0]     sat_sum;
  logic                          id_ok;

  stt_pkg::scan_ctrl_t           scan_ctrl;
  stt_pkg::next_t                best;
  logic                          fire;

  logic [stt_pkg::SlotW-1:0]     fire_id;
  logic                          out_last;

  // Saturating deadline: now + offset, clamp on carry out.
  assign sum_ext = {1'b0, item_q.now_ms} + {1'b0, item_q.offset_ms};
  assign sat_sum = sum_ext[stt_pkg::TimeW] ? '1 : sum_ext[stt_pkg::TimeW-1:0];
  assign id_ok   = int'(item_q.task_id) < stt_pkg::MaxTasks;

  assign ram_waddr = item_q.task_id[stt_pkg::SlotW-1:0];

  always_comb begin
    state_d         = state_q;
    item_d          = item_q;
    armed_d         = armed_q;
    mask_d          = mask_q;
    iss_d           = iss_q;
    iss_done_d      = iss_done_q;
    proc_vld_d      = 1'b0;
    proc_idx_d      = proc_idx_q;
    ram_we          = 1'b0;
    ram_raddr       = iss_q;
    scan_ctrl.clear = 1'b0;
    scan_ctrl.step  = 1'b0;
    scan_ctrl.tick  = (stt_pkg::cmd_e'(item_q.cmd) == stt_pkg::CMD_TICK);
    scan_ctrl.slot  = proc_idx_q;

    case (state_q)
      stt_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          item_d          = in_i;
          mask_d          = '0;
          iss_d           = '0;
          iss_done_d      = 1'b0;
          scan_ctrl.clear = 1'b1;
          state_d = (stt_pkg::cmd_e'(in_i.cmd) == stt_pkg::CMD_TICK) ?
                    stt_pkg::ST_SCAN : stt_pkg::ST_APPLY;
        end
      end
      stt_pkg::ST_APPLY: begin
        if (id_ok) begin
          case (stt_pkg::cmd_e'(item_q.cmd))
            stt_pkg::CMD_SCHEDULE: begin
              ram_we             = 1'b1;
              armed_d[ram_waddr] = 1'b1;
            end
            stt_pkg::CMD_CANCEL: begin
              armed_d[ram_waddr] = 1'b0;
            end
            default: begin
            end
          endcase
        end
        state_d = stt_pkg::ST_SCAN;
      end
      stt_pkg::ST_SCAN: begin
        // Issue one RAM read per cycle; process the slot read last cycle.
        if (!iss_done_q) begin
          proc_vld_d = 1'b1;
          proc_idx_d = iss_q;
          iss_d      = iss_q + stt_pkg::SlotW'(1);
          if (iss_q == LastSlot) begin
            iss_done_d = 1'b1;
          end
        end
        if (proc_vld_q) begin
          scan_ctrl.step = 1'b1;
          if (fire) begin
            armed_d[proc_idx_q] = 1'b0;
            mask_d[proc_idx_q]  = 1'b1;
          end
          if (proc_idx_q == LastSlot) begin
            state_d = stt_pkg::ST_EMIT;
          end
        end
      end
      stt_pkg::ST_EMIT: begin
        if (out_ready_i) begin
          // Drop the lowest fired slot just reported.
          mask_d = mask_q & (mask_q - stt_pkg::MaxTasks'(1));
          if (out_last) begin
            state_d = stt_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = stt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= stt_pkg::ST_IDLE;
      armed_q    <= '0;
      mask_q     <= '0;
      iss_q      <= '0;
      iss_done_q <= 1'b0;
      proc_vld_q <= 1'b0;
      proc_idx_q <= '0;
    end else begin
      state_q    <= state_d;
      armed_q    <= armed_d;
      mask_q     <= mask_d;
      iss_q      <= iss_d;
      iss_done_q <= iss_done_d;
      proc_vld_q <= proc_vld_d;
      proc_idx_q <= proc_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  stt_ram #(
    .Width (stt_pkg::TimeW),
    .Depth (stt_pkg::MaxTasks)
  ) u_deadline_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (sat_sum),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  stt_scan u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (scan_ctrl),
    .armed_i    (armed_q[proc_idx_q]),
    .deadline_i (ram_rdata),
    .now_i      (item_q.now_ms),
    .fire_o     (fire),
    .best_o     (best)
  );

  // Lowest fired slot still to report.
  always_comb begin
    fire_id = '0;
    for (int i = stt_pkg::MaxTasks - 1; i >= 0; i--) begin
      if (mask_q[i]) begin
        fire_id = stt_pkg::SlotW'(i);
      end
    end
  end

  assign out_last = ~|(mask_q & (mask_q - stt_pkg::MaxTasks'(1)));

  assign in_ready_o          = (state_q == stt_pkg::ST_IDLE);
  assign out_valid_o         = (state_q == stt_pkg::ST_EMIT);
  assign out_o.fired_valid   = |mask_q;
  assign out_o.fired_id      = stt_pkg::IdW'(fire_id);
  assign out_o.last          = out_last;
  assign out_o.next_valid    = best.valid;
  assign out_o.next_id       = stt_pkg::IdW'(best.id);
  assign out_o.next_deadline = best.deadline;

  `STT_ASSERT(a_no_overlap, clk_i, rst_ni, !(out_valid_o && in_ready_o))
  `STT_ASSERT(a_fired_freed, clk_i, rst_ni,
    out_valid_o && out_o.fired_valid |-> !armed_q[out_o.fired_id[stt_pkg::SlotW-1:0]])
  `STT_ASSERT(a_next_armed, clk_i, rst_ni,
    out_valid_o && out_o.next_valid |-> armed_q[out_o.next_id[stt_pkg::SlotW-1:0]])
  `STT_ASSERT(a_last_to_idle, clk_i, rst_ni,
    out_valid_o && out_ready_i && out_o.last |=> in_ready_o)

endmodule

// ----- bench/software_timer_table_tb.sv -----
// ----------------------------------------------------------------------------
// software_timer_table_tb
// Self-checking bench for the one-shot timer table. A directed table covers
// empty ticks, unused commands, overwrite, saturation and a full sixteen-slot
// fire. Random timer traffic follows, with re-arming of fired slots, under
// several idle and stall mixes and one long output hold-off. Directed rows may
// carry a literal result; an in-bench slot table model predicts the rest.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module software_timer_table_tb;

  localparam logic [stt_pkg::CmdW-1:0] CmdUnused = 2'd3;
  localparam int WatchdogLimit = 4000;
  localparam int HoldCycles    = 400;
  localparam int DrainCycles   = 40;
  localparam int PhaseItems    = 100;

  typedef struct packed {
    stt_pkg::stt_in_t  item;
    bit                has_lit;
    stt_pkg::stt_out_t lit;
  } feed_t;

  localparam stt_pkg::stt_out_t LitEmpty = '{fired_valid: 1'b0, fired_id: 4'd0, last: 1'b1,
                                             next_valid: 1'b0, next_id: 4'd0,
                                             next_deadline: 32'd0};
  localparam stt_pkg::stt_out_t LitSat   = '{fired_valid: 1'b0, fired_id: 4'd0, last: 1'b1,
                                             next_valid: 1'b1, next_id: 4'd15,
                                             next_deadline: 32'hFFFF_FFFF};
  localparam stt_pkg::stt_out_t LitNone  = '0;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  stt_pkg::stt_in_t   in_i        = '0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  stt_pkg::stt_out_t  out_o;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;

  software_timer_table DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_o       (out_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i)
  );

  // Shadow of the slot table.
  bit                        slot_armed    [stt_pkg::MaxTasks];
  logic [stt_pkg::TimeW-1:0] slot_deadline [stt_pkg::MaxTasks];

  feed_t                     feed_q[$];
  stt_pkg::stt_out_t         expected_results[$];
  logic [stt_pkg::IdW-1:0]   fired_log[$];
  int                        pushed_count   = 0;
  int                        accepted_count = 0;
  int                        error_count    = 0;
  int                        send_idle_pct  = 0;
  int                        recv_stall_pct = 0;
  int                        hold_requests  = 0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  function automatic stt_pkg::stt_out_t earliest_slot();
    stt_pkg::stt_out_t r;
    r = '0;
    for (int i = 0; i < stt_pkg::MaxTasks; i++) begin
      if (slot_armed[i] && (!r.next_valid || slot_deadline[i] < r.next_deadline)) begin
        r.next_valid    = 1'b1;
        r.next_id       = stt_pkg::IdW'(i);
        r.next_deadline = slot_deadline[i];
      end
    end
    return r;
  endfunction

  // Apply one accepted item to the shadow table and queue its results.
  task automatic apply_timer_cmd(input feed_t f);
    logic [stt_pkg::TimeW:0]  sum;
    logic [stt_pkg::IdW-1:0]  fired_ids[$];
    stt_pkg::stt_out_t        res;
    stt_pkg::stt_out_t        nxt;
    case (f.item.cmd)
      stt_pkg::CMD_SCHEDULE: begin
        if (int'(f.item.task_id) < stt_pkg::MaxTasks) begin
          sum = {1'b0, f.item.now_ms} + {1'b0, f.item.offset_ms};
          slot_deadline[f.item.task_id] = sum[stt_pkg::TimeW] ? '1 :
                                          sum[stt_pkg::TimeW-1:0];
          slot_armed[f.item.task_id]    = 1'b1;
        end
      end
      stt_pkg::CMD_CANCEL: begin
        if (int'(f.item.task_id) < stt_pkg::MaxTasks) slot_armed[f.item.task_id] = 1'b0;
      end
      stt_pkg::CMD_TICK: begin
        for (int i = 0; i < stt_pkg::MaxTasks; i++) begin
          if (slot_armed[i] && slot_deadline[i] <= f.item.now_ms) begin
            slot_armed[i] = 1'b0;
            fired_ids = {fired_ids, stt_pkg::IdW'(i)};
          end
        end
      end
      default: ;
    endcase
    nxt = earliest_slot();
    if (fired_ids.size() == 0) begin
      res = nxt;
      res.last = 1'b1;
      expected_results = {expected_results, (f.has_lit ? f.lit : res)};
    end else begin
      foreach (fired_ids[k]) begin
        res             = nxt;
        res.fired_valid = 1'b1;
        res.fired_id    = fired_ids[k];
        res.last        = (k == fired_ids.size() - 1);
        expected_results = {expected_results, res};
        fired_log        = {fired_log, fired_ids[k]};
      end
    end
  endtask

  task automatic check_result(input stt_pkg::stt_out_t got);
    stt_pkg::stt_out_t want;
    if (expected_results.size() == 0) begin
      $error("result with nothing expected: %p", got);
      error_count++;
    end else begin
      want = expected_results.pop_front();
      if (got.fired_valid !== want.fired_valid) begin
        $error("fired_valid: expected %0d, got %0d", want.fired_valid, got.fired_valid);
        error_count++;
      end
      if (got.fired_id !== want.fired_id) begin
        $error("fired_id: expected %0d, got %0d", want.fired_id, got.fired_id);
        error_count++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        error_count++;
      end
      if (got.next_valid !== want.next_valid) begin
        $error("next_valid: expected %0d, got %0d", want.next_valid, got.next_valid);
        error_count++;
      end
      if (got.next_id !== want.next_id) begin
        $error("next_id: expected %0d, got %0d", want.next_id, got.next_id);
        error_count++;
      end
      if (got.next_deadline !== want.next_deadline) begin
        $error("next_deadline: expected %h, got %h", want.next_deadline, got.next_deadline);
        error_count++;
      end
    end
  endtask

  // Sender: raise valid at random, hold it with the item until accepted.
  initial begin
    bit took;
    wait (rst_ni === 1'b1);
    forever @(posedge clk_i) begin
      took = 1'b0;
      if (in_valid_i && in_ready_o) begin
        apply_timer_cmd(feed_q.pop_front());
        accepted_count++;
        took = 1'b1;
      end
      if (!in_valid_i || took) begin
        if (feed_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          in_i       <= feed_q[0].item;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off on request.
  initial begin
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    forever @(posedge clk_i) begin
      if (rst_ni && out_valid_o && out_ready_i) check_result(out_o);
      if (hold_seen != hold_requests) begin
        hold_seen = hold_requests;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WatchdogLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("software_timer_table_tb: done, errors");
    $finish;
  end

  function automatic stt_pkg::stt_in_t mk_item(logic [stt_pkg::CmdW-1:0] cmd,
                                               logic [stt_pkg::IdW-1:0] id,
                                               logic [stt_pkg::TimeW-1:0] off,
                                               logic [stt_pkg::TimeW-1:0] now);
    stt_pkg::stt_in_t it;
    it.cmd       = cmd;
    it.task_id   = id;
    it.offset_ms = off;
    it.now_ms    = now;
    return it;
  endfunction

  // Hand one item to the sender and wait for its acceptance.
  task automatic send_item(input stt_pkg::stt_in_t item, input bit has_lit,
                           input stt_pkg::stt_out_t lit);
    feed_t f;
    f.item    = item;
    f.has_lit = has_lit;
    f.lit     = lit;
    feed_q = {feed_q, f};
    pushed_count++;
    while (accepted_count != pushed_count) @(negedge clk_i);
  endtask

  typedef struct packed {
    logic [stt_pkg::CmdW-1:0]  cmd;
    logic [stt_pkg::IdW-1:0]   id;
    logic [stt_pkg::TimeW-1:0] off;
    logic [stt_pkg::TimeW-1:0] now;
    bit                        has_lit;
    stt_pkg::stt_out_t         lit;
  } dir_row_t;

  dir_row_t directed_rows [24] = '{
    '{stt_pkg::CMD_TICK,     4'd0,  32'd0,         32'd0,         1'b1, LitEmpty},
    '{stt_pkg::CMD_CANCEL,   4'd5,  32'd0,         32'd0,         1'b1, LitEmpty},
    '{CmdUnused,             4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, LitEmpty},
    '{stt_pkg::CMD_SCHEDULE, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, LitSat},
    '{stt_pkg::CMD_SCHEDULE, 4'd0,  32'd0,         32'd0,         1'b0, LitNone},
    '{stt_pkg::CMD_SCHEDULE, 4'd0,  32'd10,        32'd5,         1'b0, LitNone},
    '{stt_pkg::CMD_TICK,     4'd0,  32'd0,         32'd14,        1'b0, LitNone},
    '{stt_pkg::CMD_CANCEL,   4'd15, 32'd0,         32'd0,         1'b0, LitNone},
    '{stt_pkg::CMD_SCHEDULE, 4'd1,  32'd1,         32'd20,        1'b0, LitNone},
    '{stt_pkg::CMD_SCHEDULE, 4'd2,  32'd2,         32'd20,        1'b0, LitNone},
    '{stt_pkg::CMD_SCHEDULE, 4'd3,  32'd3,         32'd20,        1'b0, LitNone},
    '{stt_pkg::CMD_SCHEDULE, 4'd4,  32'd0,         32'd20,        1'b0, LitNone},
    '{stt_pkg::CMD_SCHEDULE, 4'd5,  32'd1,         32'd20,        1'b0, LitNone},
    '{stt_pkg::CMD_SCHEDULE, 4'd6,  32'd2,         32'd20,        1'b0, LitNone},
    '{stt_pkg::CMD_SCHEDULE, 4'd7,  32'd3,         32'd20,        1'b0, LitNone},
    '{stt_pkg::CMD_SCHEDULE, 4'd8,  32'd0,         32'd20,        1'b0, LitNone},
    '{stt_pkg::CMD_SCHEDULE, 4'd9,  32'd1,         32'd20,        1'b0, LitNone},
    '{stt_pkg::CMD_SCHEDULE, 4'd10, 32'd2,         32'd20,        1'b0, LitNone},
    '{stt_pkg::CMD_SCHEDULE, 4'd11, 32'd3,         32'd20,        1'b0, LitNone},
    '{stt_pkg::CMD_SCHEDULE, 4'd12, 32'd0,         32'd20,        1'b0, LitNone},
    '{stt_pkg::CMD_SCHEDULE, 4'd13, 32'd1,         32'd20,        1'b0, LitNone},
    '{stt_pkg::CMD_SCHEDULE, 4'd14, 32'd2,         32'd20,        1'b0, LitNone},
    '{stt_pkg::CMD_SCHEDULE, 4'd15, 32'd3,         32'd20,        1'b0, LitNone},
    '{stt_pkg::CMD_TICK,     4'd0,  32'd0,         32'hFFFF_FFFF, 1'b0, LitNone}
  };

  logic [stt_pkg::TimeW-1:0] clock_ms;
  logic [stt_pkg::IdW-1:0]   rearm_q[$];

  // Arm a handful of slots due shortly, then advance the clock past their offsets and tick.
  task automatic send_burst(inout int sent);
    int n;
    n = $urandom_range(2, stt_pkg::MaxTasks);
    repeat (n) begin
      send_item(mk_item(stt_pkg::CMD_SCHEDULE, stt_pkg::IdW'($urandom_range(0, 15)),
                        stt_pkg::TimeW'($urandom_range(0, 3)), clock_ms), 1'b0, LitNone);
      sent++;
    end
    clock_ms = clock_ms + stt_pkg::TimeW'($urandom_range(3, 10));
    send_item(mk_item(stt_pkg::CMD_TICK, 4'd0, '0, clock_ms), 1'b0, LitNone);
    sent++;
  endtask

  task automatic run_timer_traffic(input int count);
    int                        sent;
    int                        pick;
    logic [stt_pkg::TimeW-1:0] off;
    sent = 0;
    while (sent < count) begin
      // Host callback: most fired slots come back with a new offset.
      while (fired_log.size() != 0) begin
        if ($urandom_range(0, 99) < 75) rearm_q = {rearm_q, fired_log.pop_front()};
        else void'(fired_log.pop_front());
      end
      pick = $urandom_range(0, 99);
      if (rearm_q.size() != 0 && $urandom_range(0, 99) < 70) begin
        send_item(mk_item(stt_pkg::CMD_SCHEDULE, rearm_q.pop_front(),
                          stt_pkg::TimeW'($urandom_range(1, 40)), clock_ms),
                  1'b0, LitNone);
        sent++;
      end else if (pick < 30) begin
        case ($urandom_range(0, 6))
          0:       off = $urandom;
          1:       off = 32'hFFFF_FFFF - stt_pkg::TimeW'($urandom_range(0, 200));
          default: off = stt_pkg::TimeW'($urandom_range(0, 60));
        endcase
        send_item(mk_item(stt_pkg::CMD_SCHEDULE, stt_pkg::IdW'($urandom_range(0, 15)),
                          off, clock_ms), 1'b0, LitNone);
        sent++;
      end else if (pick < 40) begin
        send_item(mk_item(stt_pkg::CMD_CANCEL, stt_pkg::IdW'($urandom_range(0, 15)),
                          $urandom, $urandom), 1'b0, LitNone);
        sent++;
      end else if (pick < 75) begin
        clock_ms = clock_ms + stt_pkg::TimeW'($urandom_range(0, 30));
        send_item(mk_item(stt_pkg::CMD_TICK, stt_pkg::IdW'($urandom_range(0, 15)),
                          $urandom, clock_ms), 1'b0, LitNone);
        sent++;
      end else if (pick < 80) begin
        send_item(mk_item(CmdUnused, stt_pkg::IdW'($urandom_range(0, 15)),
                          $urandom, $urandom), 1'b0, LitNone);
        sent++;
      end else if (pick < 87) begin
        send_burst(sent);
      end else begin
        send_item(mk_item(stt_pkg::CmdW'($urandom_range(int'(stt_pkg::CMD_SCHEDULE),
                                                          int'(stt_pkg::CMD_TICK))),
                          stt_pkg::IdW'($urandom_range(0, 15)), $urandom, $urandom),
                  1'b0, LitNone);
        sent++;
      end
    end
  endtask

  initial begin
    int burst_sent;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);

    foreach (directed_rows[r]) begin
      send_item(mk_item(directed_rows[r].cmd, directed_rows[r].id,
                        directed_rows[r].off, directed_rows[r].now),
                directed_rows[r].has_lit, directed_rows[r].lit);
    end

    // No idling; start with a long output hold-off while items keep coming.
    clock_ms = 32'd1000;
    hold_requests++;
    burst_sent = 0;
    send_burst(burst_sent);
    run_timer_traffic(PhaseItems);

    send_idle_pct = 59;
    run_timer_traffic(PhaseItems);

    send_idle_pct  = 0;
    recv_stall_pct = 59;
    clock_ms       = $urandom;
    run_timer_traffic(PhaseItems);

    // Near the top of the time range: deadlines saturate and time wraps.
    send_idle_pct  = 21;
    recv_stall_pct = 21;
    clock_ms       = 32'hFFFF_FF80;
    run_timer_traffic(PhaseItems);

    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);

    if (error_count == 0 && expected_results.size() == 0) begin
      $display("software_timer_table_tb: done, clean");
    end else begin
      $display("software_timer_table_tb: done, errors");
    end
    $finish;
  end

endmodule

// ----- software_timer_table.f -----
+incdir+src
src/stt_pkg.sv
src/stt_ram.sv
src/stt_scan.sv
src/software_timer_table.sv
bench/software_timer_table_tb.sv
